>>> hw/rtl/ipv4dq_pkg.sv
// Package for the IPv4 dotted-quad parser: status codes, parse state type,
// character constants and the part-closing function. No dependencies.
package ipv4dq_pkg;

  localparam int ADDR_W = 32;
  localparam int CHAR_W = 8;
  localparam int PREFIX_W = 6;
  localparam int STATUS_W = 3;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STATUS_OK        = 3'd0;
  localparam status_t STATUS_FEW_PARTS = 3'd1;
  localparam status_t STATUS_LONG_PART = 3'd2;
  localparam status_t STATUS_OVER_255  = 3'd3;
  localparam status_t STATUS_MANY_PARTS = 3'd4;
  localparam status_t STATUS_BAD_PART  = 3'd5;
  localparam status_t STATUS_BAD_CHAR  = 3'd6;
  localparam status_t STATUS_BAD_PREFIX = 3'd7;

  localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  localparam logic [9:0] MAX_PART_VALUE = 10'd255;
  localparam logic [2:0] MAX_PART_CHARS = 3'd3;
  localparam logic [2:0] SAT_PART_CHARS = 3'd4;
  localparam logic [2:0] PART_COUNT     = 3'd4;
  localparam logic [2:0] LAST_PART      = 3'd3;
  localparam logic [PREFIX_W-1:0] PREFIX_MIN = 6'd1;
  localparam logic [PREFIX_W-1:0] PREFIX_MAX = 6'd31;
  localparam logic [PREFIX_W-1:0] ADDR_BITS  = 6'd32;

  typedef struct packed {
    logic [2:0]        part_number;
    logic [2:0]        part_chars;
    logic [9:0]        part_value;
    logic              digits_open;
    status_t           first_fault;
    logic              char_fault;
    logic [ADDR_W-1:0] address_accum;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    part_number:   3'd0,
    part_chars:    3'd0,
    part_value:    10'd0,
    digits_open:   1'b1,
    first_fault:   STATUS_OK,
    char_fault:    1'b0,
    address_accum: '0
  };

  function automatic parse_state_t close_part(parse_state_t s, logic by_dot);
    parse_state_t r;
    r = s;
    if (s.first_fault == STATUS_OK) begin
      if (s.part_chars > MAX_PART_CHARS) begin
        r.first_fault = STATUS_LONG_PART;
      end else if (s.part_value > MAX_PART_VALUE) begin
        r.first_fault = STATUS_OVER_255;
      end else if (s.part_number == LAST_PART && by_dot) begin
        r.first_fault = STATUS_MANY_PARTS;
      end else if (s.part_chars == 3'd0 ||
                   (s.part_value == 10'd0 && s.part_chars > 3'd1)) begin
        r.first_fault = STATUS_BAD_PART;
      end
    end
    r.address_accum = {s.address_accum[ADDR_W-9:0], s.part_value[7:0]};
    if (s.part_number < PART_COUNT) begin
      r.part_number = s.part_number + 3'd1;
    end
    r.part_chars  = 3'd0;
    r.part_value  = 10'd0;
    r.digits_open = 1'b1;
    return r;
  endfunction

endpackage

>>> hw/rtl/ipv4dq_if.sv
// Valid/ready channel interfaces for the IPv4 parser: text items in,
// result items out. Depends on ipv4dq_pkg.
interface ipv4dq_text_if;
  logic                                   valid;
  logic                                   ready;
  logic [ipv4dq_pkg::CHAR_W-1:0]          character;
  logic                                   last;
  logic [ipv4dq_pkg::PREFIX_W-1:0]        prefix_len;

  modport source (output valid, output character, output last, output prefix_len,
                  input ready);
  modport sink (input valid, input character, input last, input prefix_len,
                output ready);
endinterface

interface ipv4dq_result_if;
  logic                          valid;
  logic                          ready;
  logic [ipv4dq_pkg::ADDR_W-1:0] network_address;
  ipv4dq_pkg::status_t           status;

  modport source (output valid, output network_address, output status, input ready);
  modport sink (input valid, input network_address, input status, output ready);
endinterface

>>> hw/rtl/ipv4dq_step.sv
// Per-character parse step: next parse state, final status and masked
// network address. Depends on ipv4dq_pkg.
module ipv4dq_step (
  input  ipv4dq_pkg::parse_state_t          cur,
  input  logic [ipv4dq_pkg::CHAR_W-1:0]     character,
  input  logic                              last,
  input  logic [ipv4dq_pkg::PREFIX_W-1:0]   prefix_len,
  output ipv4dq_pkg::parse_state_t          next,
  output logic [ipv4dq_pkg::ADDR_W-1:0]     network_address,
  output ipv4dq_pkg::status_t               status
);

  ipv4dq_pkg::parse_state_t s;
  ipv4dq_pkg::parse_state_t fin;
  logic                     is_digit;
  logic [7:0]               digit;
  logic [5:0]               shift;

  always_comb begin
    is_digit = (character >= ipv4dq_pkg::CHAR_ZERO) &&
               (character <= ipv4dq_pkg::CHAR_NINE);
    digit = character - ipv4dq_pkg::CHAR_ZERO;
    s = cur;
    if (character == ipv4dq_pkg::CHAR_DOT) begin
      s = ipv4dq_pkg::close_part(cur, 1'b1);
    end else begin
      if (!is_digit) begin
        s.char_fault = 1'b1;
      end
      if (cur.digits_open && is_digit && cur.part_chars < ipv4dq_pkg::MAX_PART_CHARS) begin
        s.part_value = (cur.part_value << 3) + (cur.part_value << 1) + {6'd0, digit[3:0]};
      end else begin
        s.digits_open = 1'b0;
      end
      if (cur.part_chars < ipv4dq_pkg::SAT_PART_CHARS) begin
        s.part_chars = cur.part_chars + 3'd1;
      end
    end

    fin = ipv4dq_pkg::close_part(s, 1'b0);
    status = fin.first_fault;
    if (status == ipv4dq_pkg::STATUS_OK && fin.part_number < ipv4dq_pkg::PART_COUNT) begin
      status = ipv4dq_pkg::STATUS_FEW_PARTS;
    end
    if (status == ipv4dq_pkg::STATUS_OK && fin.char_fault) begin
      status = ipv4dq_pkg::STATUS_BAD_CHAR;
    end
    if (status == ipv4dq_pkg::STATUS_OK &&
        (prefix_len < ipv4dq_pkg::PREFIX_MIN || prefix_len > ipv4dq_pkg::PREFIX_MAX)) begin
      status = ipv4dq_pkg::STATUS_BAD_PREFIX;
    end
    shift = ipv4dq_pkg::ADDR_BITS - prefix_len;
    network_address = '0;
    if (status == ipv4dq_pkg::STATUS_OK) begin
      network_address = fin.address_accum & ({ipv4dq_pkg::ADDR_W{1'b1}} << shift[4:0]);
    end

    next = last ? ipv4dq_pkg::PARSE_RESET : s;
  end

endmodule

>>> hw/rtl/ipv4_dotted_quad_network_address.sv
// Top level of the IPv4 dotted-quad parser with prefix mask.
// Depends on ipv4dq_pkg, ipv4dq_if and ipv4dq_step.
//
// Takes the address text one character per item and, on the item marked
// last, delivers one result: a status code and the address ANDed with a
// mask of prefix_len leading ones (zero unless the status is ok). Each item
// passes an input register, then one step of parse logic into the parse
// state and the result register; one character is taken every cycle except
// when a last character waits, and results come from the result register.
// Characters keep flowing while a result waits; only a last character waits
// in the input register until the result register is free.
module ipv4_dotted_quad_network_address (
  input logic            clk,
  input logic            rst,
  ipv4dq_text_if.sink    text,
  ipv4dq_result_if.source result
);

  logic                                 in_valid;
  logic [ipv4dq_pkg::CHAR_W-1:0]        in_character;
  logic                                 in_last;
  logic [ipv4dq_pkg::PREFIX_W-1:0]      in_prefix_len;
  logic                                 advance;

  ipv4dq_pkg::parse_state_t             state;
  ipv4dq_pkg::parse_state_t             state_next;
  logic [ipv4dq_pkg::ADDR_W-1:0]        addr_next;
  ipv4dq_pkg::status_t                  status_next;

  logic                                 out_valid;
  logic [ipv4dq_pkg::ADDR_W-1:0]        out_address;
  ipv4dq_pkg::status_t                  out_status;

  assign advance = in_valid && (!in_last || !out_valid || result.ready);
  assign text.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
    if (text.ready && text.valid) begin
      in_character  <= text.character;
      in_last       <= text.last;
      in_prefix_len <= text.prefix_len;
    end
  end

  ipv4dq_step u_step (
    .cur             (state),
    .character       (in_character),
    .last            (in_last),
    .prefix_len      (in_prefix_len),
    .next            (state_next),
    .network_address (addr_next),
    .status          (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ipv4dq_pkg::PARSE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (advance && in_last) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance && in_last) begin
      out_address <= addr_next;
      out_status  <= status_next;
    end
  end

  assign result.valid           = out_valid;
  assign result.network_address = out_address;
  assign result.status          = out_status;

endmodule

>>> tb/ipv4dq_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the IPv4 dotted-quad parser: tracks accepted text items,
// predicts each result and compares it with the result channel.
// Uses ipv4dq_pkg, ipv4dq_if.
module ipv4dq_result_checker (
  input  logic     clk,
  input  logic     rst,
  ipv4dq_text_if   text,
  ipv4dq_result_if result,
  output int       errors,
  output int       pending
);

  typedef struct packed {
    logic [ipv4dq_pkg::ADDR_W-1:0] addr;
    ipv4dq_pkg::status_t           status;
  } net_result_t;

  net_result_t expected_results[$];
  int mismatch_cnt = 0;
  int pending_cnt = 0;

  logic [2:0]                    parts_seen;
  logic [2:0]                    part_len;
  logic [9:0]                    part_val;
  logic                          in_digits;
  ipv4dq_pkg::status_t           fault;
  logic                          stray_char;
  logic [ipv4dq_pkg::ADDR_W-1:0] addr_acc;

  assign errors  = mismatch_cnt;
  assign pending = pending_cnt;

  function automatic void clear_parse();
    parts_seen = '0;
    part_len   = '0;
    part_val   = '0;
    in_digits  = 1'b1;
    fault      = ipv4dq_pkg::STATUS_OK;
    stray_char = 1'b0;
    addr_acc   = '0;
  endfunction

  function automatic void end_part(logic by_dot);
    if (fault == ipv4dq_pkg::STATUS_OK) begin
      if (part_len > 3'd3) begin
        fault = ipv4dq_pkg::STATUS_LONG_PART;
      end else if (part_val > 10'd255) begin
        fault = ipv4dq_pkg::STATUS_OVER_255;
      end else if (parts_seen == 3'd3 && by_dot) begin
        fault = ipv4dq_pkg::STATUS_MANY_PARTS;
      end else if (part_len == 3'd0 || (part_val == 10'd0 && part_len > 3'd1)) begin
        fault = ipv4dq_pkg::STATUS_BAD_PART;
      end
    end
    addr_acc = {addr_acc[ipv4dq_pkg::ADDR_W-9:0], part_val[7:0]};
    if (parts_seen < 3'd4) begin
      parts_seen = parts_seen + 3'd1;
    end
    part_len  = '0;
    part_val  = '0;
    in_digits = 1'b1;
  endfunction

  function automatic void parse_char(logic [ipv4dq_pkg::CHAR_W-1:0] ch, logic lst,
                                     logic [ipv4dq_pkg::PREFIX_W-1:0] pfx);
    logic        is_digit;
    net_result_t res;
    is_digit = (ch >= ipv4dq_pkg::CHAR_ZERO) && (ch <= ipv4dq_pkg::CHAR_NINE);
    if (ch == ipv4dq_pkg::CHAR_DOT) begin
      end_part(1'b1);
    end else begin
      if (!is_digit) begin
        stray_char = 1'b1;
      end
      if (in_digits && is_digit && part_len < 3'd3) begin
        part_val = part_val * 10'd10 + 10'(ch - ipv4dq_pkg::CHAR_ZERO);
      end else begin
        in_digits = 1'b0;
      end
      if (part_len < 3'd4) begin
        part_len = part_len + 3'd1;
      end
    end
    if (lst) begin
      end_part(1'b0);
      res.status = fault;
      res.addr   = '0;
      if (res.status == ipv4dq_pkg::STATUS_OK && parts_seen < 3'd4)
        res.status = ipv4dq_pkg::STATUS_FEW_PARTS;
      if (res.status == ipv4dq_pkg::STATUS_OK && stray_char)
        res.status = ipv4dq_pkg::STATUS_BAD_CHAR;
      if (res.status == ipv4dq_pkg::STATUS_OK && (pfx < 6'd1 || pfx > 6'd31))
        res.status = ipv4dq_pkg::STATUS_BAD_PREFIX;
      if (res.status == ipv4dq_pkg::STATUS_OK) begin
        res.addr = addr_acc & (32'hFFFF_FFFF << (6'd32 - pfx));
      end
      expected_results.push_back(res);
      clear_parse();
    end
  endfunction

  function automatic void flag(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
  endfunction

  always @(posedge clk) begin
    net_result_t want;
    if (rst) begin
      clear_parse();
      expected_results.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          flag($sformatf("unexpected item addr=%h status=%0d",
                         result.network_address, result.status));
        end else begin
          want = expected_results.pop_front();
          if (want.addr !== result.network_address || want.status !== result.status) begin
            flag($sformatf("addr exp=%h got=%h, status exp=%0d got=%0d",
                           want.addr, result.network_address, want.status, result.status));
          end
        end
      end
      if (text.valid && text.ready) begin
        parse_char(text.character, text.last, text.prefix_len);
      end
    end
    pending_cnt <= expected_results.size();
  end

endmodule

>>> tb/ipv4_dotted_quad_network_address_tb.sv
`timescale 1ns / 100ps
// Testbench top for ipv4_dotted_quad_network_address: drives address text with
// random idling and result stalls, and gives the verdict from ipv4dq_result_checker.
module ipv4_dotted_quad_network_address_tb;

  typedef logic [ipv4dq_pkg::CHAR_W-1:0]   char_t;
  typedef logic [ipv4dq_pkg::PREFIX_W-1:0] prefix_t;

  localparam int TARGET_CHARS = 1950;
  localparam int CYCLE_LIMIT  = 500000;

  logic clk;
  logic rst;
  int   address_errors;
  int   results_pending;
  int   cycles = 0;
  int   chars_sent = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   stall_left = 0;
  bit   calm = 1'b0;

  char_t text_q[$];

  ipv4dq_text_if   text_ch();
  ipv4dq_result_if result_ch();

  ipv4_dotted_quad_network_address dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  ipv4dq_result_checker address_check (
    .clk     (clk),
    .rst     (rst),
    .text    (text_ch),
    .result  (result_ch),
    .errors  (address_errors),
    .pending (results_pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** ipv4_dotted_quad_network_address: FAILED **");
      $finish;
    end
  end

  initial result_ch.ready = 1'b0;

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 17) - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic char_t odd_char();
    string forms = "+- eE/:x";
    if ($urandom_range(0, 1)) return forms[$urandom_range(0, forms.len() - 1)];
    return char_t'($urandom_range(0, 255));
  endfunction

  // mostly legal parts; the rest hit each part rule
  function automatic void add_part(bit clean);
    int r;
    int n;
    r = clean ? 0 : $urandom_range(0, 99);
    if (r < 60) begin
      add_str($sformatf("%0d", $urandom_range(0, 255)));
    end else if (r < 68) begin
      add_str($urandom_range(0, 1) ? "00" : $sformatf("0%0d", $urandom_range(0, 99)));
    end else if (r < 78) begin
      n = $urandom_range(1, 5);
      repeat (n) text_q.push_back(char_t'(ipv4dq_pkg::CHAR_ZERO + $urandom_range(0, 9)));
    end else if (r < 83) begin
      // empty part
    end else if (r < 92) begin
      add_str($sformatf("%0d", $urandom_range(0, 255)));
      text_q.insert($urandom_range(0, 2) == 0 ? text_q.size() : 0, odd_char());
    end else begin
      add_str($sformatf("%0d", $urandom_range(256, 999)));
    end
  endfunction

  task automatic put_char(char_t ch, logic lst, prefix_t pfx);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      text_ch.valid <= 1'b0;
      text_ch.character <= char_t'($urandom_range(0, 255));
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    text_ch.valid      <= 1'b1;
    text_ch.character  <= ch;
    text_ch.last       <= lst;
    text_ch.prefix_len <= pfx;
    do @(posedge clk); while (!text_ch.ready);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(prefix_t pfx);
    if (text_q.size() == 0) text_q.push_back(ipv4dq_pkg::CHAR_ZERO);
    foreach (text_q[i]) begin
      put_char(text_q[i], i == text_q.size() - 1,
               i == text_q.size() - 1 ? pfx : prefix_t'($urandom_range(0, 63)));
    end
    text_q.delete();
  endtask

  string dir_text[18] = '{
    "0.0.0.0", "255.255.255.255", "1.2.3", "1234.5.6.7", "256.1.1.1",
    "1.2.3.4.5", "1..2.3", "00.1.1.1", "1.2.3.a", "10.1.2.3", "10.1.2.3",
    "10.1.2.3", "1.2.3.4.", "+1.2.3.4", "1e2.0.0.1", "12a.1.1.1", "5", "."
  };
  int dir_pfx[18] = '{1, 31, 8, 8, 8, 8, 8, 8, 8, 0, 32, 63, 24, 24, 24, 24, 24, 16};

  initial begin
    int  nparts;
    int  addr_cnt;
    bit  clean;
    rst = 1'b1;
    text_ch.valid = 1'b0;
    text_ch.character = '0;
    text_ch.last = 1'b0;
    text_ch.prefix_len = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    idle_pct  = 20;
    stall_pct = 20;
    foreach (dir_text[i]) begin
      add_str(dir_text[i]);
      send_text(prefix_t'(dir_pfx[i]));
    end
    // raw byte extremes
    text_q = '{8'h00, ipv4dq_pkg::CHAR_DOT, 8'hFF, ipv4dq_pkg::CHAR_DOT,
               ipv4dq_pkg::CHAR_NINE, ipv4dq_pkg::CHAR_DOT, ipv4dq_pkg::CHAR_ZERO};
    send_text(6'd12);
    add_str("199.99.9.0");
    send_text(6'd31);

    addr_cnt = 0;
    while (chars_sent < TARGET_CHARS) begin
      if (addr_cnt % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 35;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      calm = chars_sent > TARGET_CHARS * 85 / 100;
      if ($urandom_range(0, 99) < 75) begin
        clean  = 1'($urandom_range(0, 1));
        nparts = ($urandom_range(0, 99) < 80 || clean) ? 4 : $urandom_range(1, 6);
        for (int p = 0; p < nparts; p++) begin
          if (p != 0) text_q.push_back(ipv4dq_pkg::CHAR_DOT);
          add_part(clean);
        end
        if (!clean && $urandom_range(0, 99) < 4) text_q.push_back(ipv4dq_pkg::CHAR_DOT);
      end else begin
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 2))
            0: text_q.push_back(char_t'(ipv4dq_pkg::CHAR_ZERO + $urandom_range(0, 9)));
            1: text_q.push_back(ipv4dq_pkg::CHAR_DOT);
            default: text_q.push_back(char_t'($urandom_range(0, 255)));
          endcase
        end
      end
      send_text(prefix_t'($urandom_range(0, 99) < 80 ? $urandom_range(1, 31)
                                                     : $urandom_range(0, 63)));
      addr_cnt++;
    end
    text_ch.valid <= 1'b0;

    while (results_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (address_errors == 0) begin
      $display("** ipv4_dotted_quad_network_address: PASSED **");
    end else begin
      $display("** ipv4_dotted_quad_network_address: FAILED **");
    end
    $finish;
  end

endmodule
